// ===== sv/ttsr_pkg.sv =====
package ttsr_pkg;

  // table geometry
  localparam int unsigned TableDepth = 4096;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = 13;
  localparam int unsigned LatW       = 28;
  localparam int unsigned TolW       = 20;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 20;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OpLoad   = 2'd0,
    OpSearch = 2'd1,
    OpFetch  = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgEntries  = 2'd0,
    CfgPoints   = 2'd1,
    CfgNorthern = 2'd2,
    CfgTol      = 2'd3
  } cfg_e;

  // input transaction payload
  typedef struct packed {
    logic [1:0]             operation;
    logic [11:0]            entry_index;
    logic signed [LatW-1:0] latitude_in;
  } in_t;

  // output transaction payload
  typedef struct packed {
    logic signed [LatW-1:0] latitude_out;
    logic [11:0]            position;
    logic                   close_match;
    logic                   last_of_run;
  } out_t;

  // table memory access
  typedef struct packed {
    logic                   we;
    logic [IdxW-1:0]        waddr;
    logic signed [LatW-1:0] wdata;
    logic                   re;
    logic [IdxW-1:0]        raddr;
  } mem_req_t;

endpackage

// ===== sv/ttsr_table.sv =====
module ttsr_table
  import ttsr_pkg::*;
(
  input  logic                   clk_i,
  input  mem_req_t               req_i,
  output logic signed [LatW-1:0] rdata_o
);

  logic signed [LatW-1:0] mem_q [TableDepth];
  logic signed [LatW-1:0] rdata_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tolerant_table_search_readout.sv =====
// Latitude table with tolerant bisection search and a wrapping readout cursor.
// Input channel (in_valid_i/in_ready_o, in_data_i) carries three kinds of
// transaction: load writes one table entry, search bisects the descending
// table for a start latitude, fetch reads the entry under the cursor and
// steps the cursor. Loads give no result; search and fetch each give one
// result on the output channel (out_valid_o/out_ready_i, out_data_o).
// A load leaves the block idle and ready for another item. A fetch issues
// a registered table read, then moves the entry to the output register; a
// search probes at most about log2(entries_in_use) entries, 12 for a full
// table, each probe waiting on one registered read of the table memory,
// then moves the found position there. No new item is taken before the
// result is in the output register. Configuration (cfg_we_i, cfg_idx_i,
// cfg_wdata_i) is to be written by the user only while idle; the block
// itself does not enforce this. Reset clears cursor, run count and output
// valid and restores register defaults; table contents are undefined until
// loaded. A stalled receiver holds the result in the output register; the
// block keeps taking loads and finishes the next search or fetch, then
// waits until the output register frees up.
module tolerant_table_search_readout
  import ttsr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o
);

  typedef enum logic [2:0] {
    StIdle,
    StProbe,
    StCmp,
    StSrchDone,
    StFetch
  } state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        ent_q, ent_d;
  logic [CntW-1:0]        pts_q, pts_d;
  logic                   north_q, north_d;
  logic [TolW-1:0]        tol_q, tol_d;
  logic [IdxW-1:0]        cursor_q, cursor_d;
  logic [CntW-1:0]        ec_q, ec_d;
  logic [IdxW-1:0]        lo_q, lo_d;
  logic [IdxW-1:0]        hi_q, hi_d;
  logic [IdxW-1:0]        mid_q, mid_d;
  logic signed [LatW-1:0] lat_q, lat_d;
  logic [IdxW-1:0]        found_q, found_d;
  logic                   close_q, close_d;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, out_d;

  mem_req_t               mem_req;
  logic signed [LatW-1:0] rd_data;

  logic [IdxW-1:0]        nm1;
  logic [CntW-1:0]        run_len;
  logic                   out_free;

  ttsr_table u_table (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(rd_data)
  );

  // last valid index from the clamped entry count
  always_comb begin
    if (ent_q == '0) begin
      nm1 = '0;
    end else if (ent_q > CntW'(TableDepth)) begin
      nm1 = IdxW'(TableDepth - 1);
    end else begin
      nm1 = IdxW'(ent_q - CntW'(1));
    end
  end

  assign run_len  = (pts_q == '0) ? CntW'(1) : pts_q;
  assign out_free = !out_valid_q || out_ready_i;

  // next state and datapath
  always_comb begin
    logic [IdxW:0]        sum;
    logic signed [LatW:0] diff;
    logic [LatW:0]        abs_diff;
    logic                 is_close;
    logic                 go_south;
    logic [IdxW-1:0]      lo_n;
    logic [IdxW-1:0]      hi_n;
    logic [IdxW:0]        nsum;
    logic [IdxW:0]        inc;
    logic [CntW-1:0]      ec_inc;
    logic                 last;

    state_d     = state_q;
    ent_d       = ent_q;
    pts_d       = pts_q;
    north_d     = north_q;
    tol_d       = tol_q;
    cursor_d    = cursor_q;
    ec_d        = ec_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    lat_d       = lat_q;
    found_d     = found_q;
    close_d     = close_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_req     = '0;

    // probe compare against the entry read last cycle
    diff     = (LatW+1)'(lat_q) - (LatW+1)'(rd_data);
    abs_diff = diff[LatW] ? (LatW+1)'(0) - diff : diff;
    is_close = abs_diff < (LatW+1)'(tol_q);
    go_south = lat_q < rd_data;
    lo_n     = go_south ? mid_q : lo_q;
    hi_n     = go_south ? hi_q : mid_q;
    nsum     = {1'b0, lo_n} + {1'b0, hi_n};
    sum      = {1'b0, lo_q} + {1'b0, hi_q};

    // cursor step and run count for a fetch
    inc    = {1'b0, cursor_q} + (IdxW+1)'(1);
    ec_inc = ec_q + CntW'(1);
    last   = ec_inc >= run_len;

    // configuration writes
    if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CfgEntries:  ent_d   = cfg_wdata_i[CntW-1:0];
        CfgPoints:   pts_d   = cfg_wdata_i[CntW-1:0];
        CfgNorthern: north_d = cfg_wdata_i[0];
        CfgTol:      tol_d   = cfg_wdata_i[TolW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          unique case (in_data_i.operation)
            OpLoad: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = in_data_i.entry_index;
              mem_req.wdata = in_data_i.latitude_in;
            end
            OpSearch: begin
              lat_d   = in_data_i.latitude_in;
              lo_d    = '0;
              hi_d    = nm1;
              state_d = StProbe;
            end
            OpFetch: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = cursor_q;
              state_d       = StFetch;
            end
            default: ;
          endcase
        end
      end
      StProbe: begin
        if ((hi_q - lo_q) > IdxW'(1)) begin
          mid_d         = sum[IdxW:1];
          mem_req.re    = 1'b1;
          mem_req.raddr = sum[IdxW:1];
          state_d       = StCmp;
        end else begin
          found_d = lo_q;
          close_d = 1'b0;
          state_d = StSrchDone;
        end
      end
      StCmp: begin
        if (is_close) begin
          found_d = mid_q;
          close_d = 1'b1;
          state_d = StSrchDone;
        end else begin
          lo_d = lo_n;
          hi_d = hi_n;
          if ((hi_n - lo_n) > IdxW'(1)) begin
            mid_d         = nsum[IdxW:1];
            mem_req.re    = 1'b1;
            mem_req.raddr = nsum[IdxW:1];
          end else begin
            found_d = lo_n;
            close_d = 1'b0;
            state_d = StSrchDone;
          end
        end
      end
      StSrchDone: begin
        if (out_free) begin
          out_d.latitude_out = '0;
          out_d.position     = found_q;
          out_d.close_match  = close_q;
          out_d.last_of_run  = 1'b0;
          out_valid_d        = 1'b1;
          cursor_d           = found_q;
          ec_d               = '0;
          state_d            = StIdle;
        end
      end
      StFetch: begin
        if (out_free) begin
          out_d.latitude_out = rd_data;
          out_d.position     = cursor_q;
          out_d.close_match  = 1'b0;
          out_d.last_of_run  = last;
          out_valid_d        = 1'b1;
          ec_d               = last ? '0 : ec_inc;
          if (north_q) begin
            cursor_d = (cursor_q == '0) ? nm1 : cursor_q - IdxW'(1);
          end else begin
            cursor_d = (inc > {1'b0, nm1}) ? '0 : inc[IdxW-1:0];
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ent_q       <= CntW'(2);
      pts_q       <= CntW'(1);
      north_q     <= 1'b0;
      tol_q       <= TolW'(1000);
      cursor_q    <= '0;
      ec_q        <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      lat_q       <= '0;
      found_q     <= '0;
      close_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      ent_q       <= ent_d;
      pts_q       <= pts_d;
      north_q     <= north_d;
      tol_q       <= tol_d;
      cursor_q    <= cursor_d;
      ec_q        <= ec_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      mid_q       <= mid_d;
      lat_q       <= lat_d;
      found_q     <= found_d;
      close_q     <= close_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // probed index stays strictly inside the bracket
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StCmp |-> (lo_q < mid_q) && (mid_q < hi_q))
    else $error("probe index outside search bracket");

  // table is written only by a load taken while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (state_q == StIdle) && in_valid_i)
    else $error("table write outside a load transaction");

  // run count stays below the run length after a fetch result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFetch) && out_free |=> ec_q < run_len)
    else $error("run count not below run length after fetch");

  // a result never flags both a close match and a run end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.close_match && out_data_o.last_of_run))
    else $error("search and fetch flags mixed in one result");

endmodule
